FILE: rtl/blsq_pkg.sv
`timescale 1ns / 1ps

package blsq_pkg;

	// Operand and result formats.
	localparam int IN_FRAC_BITS  = 32;
	localparam int IN_WIDTH      = 64;
	localparam int OUT_FRAC_BITS = 32;
	localparam int LOG_WIDTH     = 38;

	// Mantissa: one integer bit and M_WIDTH-1 fraction bits.
	localparam int M_WIDTH = 64;

	// The squaring row: N_CELLS cells, each holding one DIGIT_W-bit slice.
	localparam int DIGIT_W = 16;
	localparam int N_CELLS = M_WIDTH / DIGIT_W;
	localparam int PHASE_W = $clog2(N_CELLS);

	// Configuration register file.
	localparam int PREC_W = 6;
	localparam logic [PREC_W-1:0] PREC_RESET = 6'd32;
	localparam logic [PREC_W-1:0] PREC_MAX   = PREC_W'(OUT_FRAC_BITS);
	localparam int ADDR_W = 3;
	localparam logic REG_PRECISION = 1'b0;

	typedef struct packed {
		logic en;     // the cells take a step this cycle
		logic clear;  // the step starts a fresh product
	} cell_ctrl_t;

endpackage

FILE: rtl/binary_logarithm_by_squaring_core.sv
`timescale 1ns / 1ps
// Sequence: a zero operand gives its result strobe in the cycle after the item is accepted;
// otherwise the operand is normalised (eight-bit shifts, then one-bit shifts) and each result
// fraction bit takes one pass of the squaring row (ST_MUL phases, then ST_RES) before the strobe.
// Throughput: one item at a time; busy falls in the cycle that carries the strobe.
// Reset: arst_n clears the controller, the strobe and sets precision_bits to 32.
// The receiver cannot stall: each result is shown for exactly one cycle.

module binary_logarithm_by_squaring_core (
	input  logic                             clk,
	input  logic                             arst_n,

	// Command channel.
	input  logic                             start,
	output logic                             busy,
	input  logic [63:0]                      x_value,

	// Result channel.
	output logic                             done,
	output logic signed [blsq_pkg::LOG_WIDTH-1:0] log_value,
	output logic                             undefined,

	// Configuration port.
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [blsq_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import blsq_pkg::*;

	// Controller states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NORM8 = 3'd1;
	localparam logic [2:0] ST_NORM1 = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_RES   = 3'd4;

	localparam logic [M_WIDTH-1:0] M_ONE = {1'b1, {(M_WIDTH-1){1'b0}}};
	localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(N_CELLS - 1);

	logic [2:0]               state_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [M_WIDTH-1:0]       m_q;
	logic [5:0]               p_q;
	logic [PREC_W-1:0]        iter_q;
	logic [PREC_W-1:0]        nbits_q;
	logic [OUT_FRAC_BITS-1:0] frac_q;
	logic                     lo63_q;
	logic [PREC_W-1:0]        prec_q;
	logic                     done_q;
	logic [LOG_WIDTH-1:0]     log_q;
	logic                     undef_q;

	cell_ctrl_t               cell_ctrl;
	logic [DIGIT_W-1:0]       digit;
	logic [DIGIT_W-1:0]       lo_digit;
	logic [M_WIDTH-1:0]       hi;

	logic                     accept;
	logic                     cfg_wr;
	logic [IN_WIDTH-1:0]      v;
	logic [M_WIDTH-1:0]       m_nxt;
	logic [OUT_FRAC_BITS-1:0] frac_nxt;
	logic [4:0]               bit_idx;
	logic [PREC_W-1:0]        iter_inc;
	logic                     more_res;
	logic                     more_norm;
	logic [PREC_W-1:0]        nbits_in;
	logic signed [7:0]        ip;
	logic [LOG_WIDTH-1:0]     log_res;
	logic [LOG_WIDTH-1:0]     log_norm;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign log_value = log_q;
	assign undefined = undef_q;

	// Configuration port: one register, precision_bits, at byte address zero.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRECISION);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PRECISION) begin
			prdata = 32'(prec_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q <= PREC_RESET;
		end else if (cfg_wr) begin
			prec_q <= pwdata[PREC_W-1:0];
		end
	end

	// The squaring row is fed one digit of the mantissa per cycle, lowest first,
	// while every cell multiplies it by its own slice of the same mantissa.
	assign cell_ctrl.en    = (state_q == ST_MUL);
	assign cell_ctrl.clear = (phase_q == '0);
	assign digit           = m_q[phase_q*DIGIT_W +: DIGIT_W];

	blsq_row u_row (
		.clk      (clk),
		.ctrl     (cell_ctrl),
		.a        (m_q),
		.b        (digit),
		.lo_digit (lo_digit),
		.hi       (hi)
	);

	always_comb begin
		v = x_value[IN_WIDTH-1:0];
		nbits_in = (prec_q > PREC_MAX) ? PREC_MAX : prec_q;

		// A square that reaches two is halved back, which is the upper product
		// half as it stands; otherwise the half is taken one bit lower.
		m_nxt    = hi[M_WIDTH-1] ? hi : {hi[M_WIDTH-2:0], lo63_q};
		bit_idx  = 5'(OUT_FRAC_BITS - 1) - iter_q[4:0];
		frac_nxt = frac_q;
		if (hi[M_WIDTH-1]) begin
			frac_nxt[bit_idx] = 1'b1;
		end
		iter_inc  = iter_q + 1'b1;
		more_res  = (iter_inc < nbits_q) && (m_nxt != M_ONE);
		more_norm = (iter_q < nbits_q) && (m_q != M_ONE);

		// Integer part is the leading one's position less the input fraction bits.
		ip = $signed({2'b00, p_q}) - $signed(8'(IN_FRAC_BITS));
		log_norm = {{(LOG_WIDTH-8){ip[7]}}, ip} << OUT_FRAC_BITS;
		log_res  = log_norm | LOG_WIDTH'(frac_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (v == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_NORM8;
						end
					end
				end
				ST_NORM8: begin
					if (m_q[M_WIDTH-1 -: 8] != '0) begin
						state_q <= ST_NORM1;
					end
				end
				ST_NORM1: begin
					if (m_q[M_WIDTH-1]) begin
						if (more_norm) begin
							state_q <= ST_MUL;
							phase_q <= '0;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == LAST_PHASE) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					phase_q <= '0;
					if (more_res) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					m_q     <= M_WIDTH'(v) << (M_WIDTH - IN_WIDTH);
					p_q     <= 6'(IN_WIDTH - 1);
					iter_q  <= '0;
					nbits_q <= nbits_in;
					frac_q  <= '0;
					if (v == '0) begin
						log_q   <= '0;
						undef_q <= 1'b1;
					end
				end
			end
			ST_NORM8: begin
				if (m_q[M_WIDTH-1 -: 8] == '0) begin
					m_q <= m_q << 8;
					p_q <= p_q - 6'd8;
				end
			end
			ST_NORM1: begin
				if (!m_q[M_WIDTH-1]) begin
					m_q <= m_q << 1;
					p_q <= p_q - 6'd1;
				end else if (!more_norm) begin
					log_q   <= log_norm | LOG_WIDTH'(frac_q);
					undef_q <= 1'b0;
				end
			end
			ST_MUL: begin
				if (phase_q == LAST_PHASE) begin
					lo63_q <= lo_digit[DIGIT_W-1];
				end
			end
			ST_RES: begin
				m_q    <= m_nxt;
				frac_q <= frac_nxt;
				iter_q <= iter_inc;
				if (!more_res) begin
					log_q   <= log_res;
					undef_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/blsq_cell.sv
`timescale 1ns / 1ps

module blsq_cell (
	input  logic                        clk,
	input  blsq_pkg::cell_ctrl_t        ctrl,
	input  logic [blsq_pkg::DIGIT_W-1:0] a,
	input  logic [blsq_pkg::DIGIT_W-1:0] b,
	input  logic [blsq_pkg::DIGIT_W-1:0] upper_lo,
	output logic [blsq_pkg::DIGIT_W-1:0] lo,
	output logic [blsq_pkg::DIGIT_W-1:0] s,
	output logic [blsq_pkg::DIGIT_W-1:0] h
);
	import blsq_pkg::*;

	logic [DIGIT_W-1:0]   s_q;
	logic [DIGIT_W-1:0]   h_q;
	logic [DIGIT_W-1:0]   acc_s;
	logic [DIGIT_W-1:0]   acc_h;
	logic [2*DIGIT_W-1:0] t;

	// The sum never exceeds 2^(2*DIGIT_W)-1, so the high half always fits one digit.
	always_comb begin
		acc_s = ctrl.clear ? '0 : s_q;
		acc_h = ctrl.clear ? '0 : h_q;
		t = (2*DIGIT_W)'(a) * (2*DIGIT_W)'(b) + (2*DIGIT_W)'(acc_s) + (2*DIGIT_W)'(acc_h);
	end

	assign lo = t[DIGIT_W-1:0];
	assign s  = s_q;
	assign h  = h_q;

	// The low digit moves one place down, the high digit stays in this cell.
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			s_q <= upper_lo;
			h_q <= t[2*DIGIT_W-1:DIGIT_W];
		end
	end

endmodule

FILE: rtl/blsq_row.sv
`timescale 1ns / 1ps

module blsq_row (
	input  logic                         clk,
	input  blsq_pkg::cell_ctrl_t         ctrl,
	input  logic [blsq_pkg::M_WIDTH-1:0] a,
	input  logic [blsq_pkg::DIGIT_W-1:0] b,
	output logic [blsq_pkg::DIGIT_W-1:0] lo_digit,
	output logic [blsq_pkg::M_WIDTH-1:0] hi
);
	import blsq_pkg::*;

	logic [DIGIT_W-1:0] lo_w [N_CELLS];
	logic [DIGIT_W-1:0] up_w [N_CELLS];
	logic [DIGIT_W-1:0] s_w  [N_CELLS];
	logic [DIGIT_W-1:0] h_w  [N_CELLS];
	logic [M_WIDTH-1:0] s_cat;
	logic [M_WIDTH-1:0] h_cat;

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		if (i == N_CELLS - 1) begin : g_top
			assign up_w[i] = '0;
		end else begin : g_mid
			assign up_w[i] = lo_w[i+1];
		end

		blsq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.a        (a[i*DIGIT_W +: DIGIT_W]),
			.b        (b),
			.upper_lo (up_w[i]),
			.lo       (lo_w[i]),
			.s        (s_w[i]),
			.h        (h_w[i])
		);
	end

	// After all digits have been fed the row holds the upper product half in
	// carry-save form; one add resolves it.
	always_comb begin
		for (int i = 0; i < N_CELLS; i++) begin
			s_cat[i*DIGIT_W +: DIGIT_W] = s_w[i];
			h_cat[i*DIGIT_W +: DIGIT_W] = h_w[i];
		end
	end

	assign hi       = s_cat + h_cat;
	assign lo_digit = lo_w[0];

endmodule
